// ===== rtl/bmp_pixel_unpacker_macros.svh =====
// Assertion macros shared by the bitmap pixel unpacker modules.
`ifndef BMP_PIXEL_UNPACKER_MACROS_SVH
`define BMP_PIXEL_UNPACKER_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising edge outside reset.
`define BPU_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define BPU_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BPU_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons, msg)
`define BPU_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons, msg)
`endif
`endif

// ===== rtl/bpu_pkg.sv =====
// Shared types and constants for the bitmap pixel unpacker.
package bpu_pkg;

  // Input word kinds
  localparam logic CMD_PIXEL   = 1'b0;
  localparam logic CMD_PALETTE = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] REG_BPP    = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  // Supported pixel depths
  localparam logic [5:0] BPP_1  = 6'd1;
  localparam logic [5:0] BPP_4  = 6'd4;
  localparam logic [5:0] BPP_8  = 6'd8;
  localparam logic [5:0] BPP_24 = 6'd24;

  // Config field widths and reset values
  localparam int CFG_DIM_W = 13;
  localparam logic [5:0]  BPP_RESET    = 6'd24;
  localparam logic [12:0] WIDTH_RESET  = 13'd640;
  localparam logic [12:0] HEIGHT_RESET = 13'd480;

  // 24 bpp byte position
  localparam logic [1:0] PHASE_BLUE  = 2'd0;
  localparam logic [1:0] PHASE_GREEN = 2'd1;
  localparam logic [1:0] PHASE_RED   = 2'd2;

  // Where the color of an issued pixel comes from
  typedef enum logic [1:0] {
    SRC_DIRECT  = 2'd0,
    SRC_PALETTE = 2'd1,
    SRC_BLACK   = 2'd2
  } color_src_t;

  // One accepted input word
  typedef struct packed {
    logic       cmd;
    logic [7:0] data_byte;
    logic [7:0] palette_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } in_word_t;

  // Palette write request
  typedef struct packed {
    logic        we;
    logic [7:0]  index;
    logic [23:0] rgb;
  } pal_wr_t;

  // One pixel result headed for the output register
  typedef struct packed {
    logic [11:0] x;
    logic [11:0] y;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  pal_index;
    color_src_t  src;
    logic        last;
    logic        done;
    logic        status;
  } pix_req_t;

endpackage

// ===== rtl/bpu_palette.sv =====
// Palette memory: one write port, one registered read port.
module bpu_palette #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic             clk,
  input  bpu_pkg::pal_wr_t wr,
  input  logic             rd_en,
  input  logic [7:0]       rd_index,
  output logic [23:0]      rd_data
);

  localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

  logic [23:0] mem [PALETTE_DEPTH];

  // Write side; index already range-checked upstream
  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.index[AW-1:0]] <= wr.rgb;
    end
  end

  // Read side, loaded together with the output register
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_index[AW-1:0]];
    end
  end

endmodule

// ===== rtl/bpu_seq.sv =====
// Word sequencer: holds one input word, walks its pixels, keeps row and column counters.
`include "bmp_pixel_unpacker_macros.svh"
module bpu_seq #(
  parameter int MAX_WIDTH     = 4096,
  parameter int MAX_HEIGHT    = 4096,
  parameter int PALETTE_DEPTH = 256
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        in_valid,
  output logic                                        in_ready,
  input  bpu_pkg::in_word_t                           in_word,
  input  logic [5:0]                                  bpp,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]              w,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]             h,
  input  logic [$clog2(MAX_WIDTH*24+1)-1:0]           padded,
  input  logic                                        out_free,
  output logic                                        issue_valid,
  output bpu_pkg::pix_req_t                           issue,
  output bpu_pkg::pal_wr_t                            pal_wr
);

  localparam int WW  = $clog2(MAX_WIDTH+1);
  localparam int WW1 = WW + 1;
  localparam int HW  = $clog2(MAX_HEIGHT+1);
  localparam int HW1 = HW + 1;
  localparam int BW  = $clog2(MAX_WIDTH*24+1);
  localparam int RBW = $clog2(MAX_WIDTH*3+4);

  // Held word and sub-pixel position within it
  logic              a_valid;
  bpu_pkg::in_word_t a_word;
  logic [2:0]        sub;

  // Image position state
  logic [WW-1:0]  column_count, column_count_next;
  logic [HW-1:0]  row_count, row_count_next;
  logic [RBW-1:0] row_byte_count, row_byte_count_next;
  logic [15:0]    partial_rgb, partial_rgb_next;
  logic [1:0]     byte_phase, byte_phase_next;
  logic [2:0]     sub_next;

  logic           supported;
  logic           col_in;
  logic           last_col;
  logic [WW1-1:0] col_p1;
  logic           emits;
  logic           finish;
  logic           pixel_step;
  logic           advance;
  logic [7:0]     pix_index;
  logic [HW-1:0]  y_full;
  logic [BW-1:0]  rbc_inc;
  logic           row_end;
  logic [WW-1:0]  col_after;

  assign supported = bpp inside {bpu_pkg::BPP_1, bpu_pkg::BPP_4, bpu_pkg::BPP_8,
                                 bpu_pkg::BPP_24};
  assign col_in    = column_count < w;
  assign col_p1    = WW1'(column_count) + WW1'(1);
  assign last_col  = col_p1 >= WW1'(w);
  assign y_full    = (row_count < h) ? (h - HW'(1) - row_count) : '0;

  // What this slot does with the held word
  always_comb begin
    emits      = 1'b0;
    finish     = 1'b1;
    pixel_step = 1'b0;
    pix_index  = a_word.data_byte;
    if (a_word.cmd == bpu_pkg::CMD_PALETTE) begin
      emits = 1'b0;
    end else if (!supported) begin
      emits = 1'b1;
    end else if (col_in) begin
      case (bpp)
        bpu_pkg::BPP_1: begin
          emits      = 1'b1;
          pixel_step = 1'b1;
          pix_index  = {7'd0, a_word.data_byte[3'd7 - sub]};
          finish     = (sub == 3'd7) || last_col;
        end
        bpu_pkg::BPP_4: begin
          emits      = 1'b1;
          pixel_step = 1'b1;
          pix_index  = sub[0] ? {4'd0, a_word.data_byte[3:0]}
                              : {4'd0, a_word.data_byte[7:4]};
          finish     = sub[0] || last_col;
        end
        bpu_pkg::BPP_8: begin
          emits      = 1'b1;
          pixel_step = 1'b1;
        end
        default: begin
          emits      = (byte_phase == bpu_pkg::PHASE_RED);
          pixel_step = (byte_phase == bpu_pkg::PHASE_RED);
        end
      endcase
    end
  end

  assign advance     = a_valid && (!emits || out_free);
  assign in_ready    = !a_valid || (advance && finish);
  assign issue_valid = advance && emits;

  // Result for this slot
  always_comb begin
    issue           = '0;
    issue.x         = 12'(column_count);
    issue.y         = 12'(y_full);
    issue.pal_index = pix_index;
    issue.last      = finish;
    issue.done      = last_col && (HW1'(row_count) + HW1'(1) >= HW1'(h));
    if (!supported) begin
      issue.x    = '0;
      issue.y    = '0;
      issue.done = 1'b0;
      issue.src  = bpu_pkg::SRC_DIRECT;
      issue.status = 1'b1;
    end else if (bpp == bpu_pkg::BPP_24) begin
      issue.src   = bpu_pkg::SRC_DIRECT;
      issue.red   = a_word.data_byte;
      issue.green = partial_rgb[15:8];
      issue.blue  = partial_rgb[7:0];
    end else if ({1'b0, pix_index} < 9'(PALETTE_DEPTH)) begin
      issue.src = bpu_pkg::SRC_PALETTE;
    end else begin
      issue.src = bpu_pkg::SRC_BLACK;
    end
  end

  // Palette writes take a slot of their own, in word order
  always_comb begin
    pal_wr.we    = advance && (a_word.cmd == bpu_pkg::CMD_PALETTE) &&
                   ({1'b0, a_word.palette_index} < 9'(PALETTE_DEPTH));
    pal_wr.index = a_word.palette_index;
    pal_wr.rgb   = {a_word.red, a_word.green, a_word.blue};
  end

  // Counter updates
  assign rbc_inc   = BW'(row_byte_count) + BW'(1);
  assign row_end   = rbc_inc >= padded;
  assign col_after = pixel_step ? WW'(col_p1) : column_count;

  always_comb begin
    column_count_next   = column_count;
    row_count_next      = row_count;
    row_byte_count_next = row_byte_count;
    partial_rgb_next    = partial_rgb;
    byte_phase_next     = byte_phase;
    sub_next            = sub;
    if (advance && (a_word.cmd == bpu_pkg::CMD_PIXEL) && supported) begin
      if (!finish) begin
        column_count_next = col_after;
        sub_next          = sub + 3'd1;
      end else begin
        sub_next = 3'd0;
        if (row_end) begin
          column_count_next   = '0;
          row_byte_count_next = '0;
          partial_rgb_next    = '0;
          byte_phase_next     = bpu_pkg::PHASE_BLUE;
          row_count_next      = (HW1'(row_count) + HW1'(1) >= HW1'(h)) ? '0
                                : row_count + HW'(1);
        end else begin
          column_count_next   = col_after;
          row_byte_count_next = RBW'(rbc_inc);
          if (col_in && (bpp == bpu_pkg::BPP_24)) begin
            case (byte_phase)
              bpu_pkg::PHASE_BLUE: begin
                partial_rgb_next = {8'd0, a_word.data_byte};
                byte_phase_next  = bpu_pkg::PHASE_GREEN;
              end
              bpu_pkg::PHASE_GREEN: begin
                partial_rgb_next = {a_word.data_byte, partial_rgb[7:0]};
                byte_phase_next  = bpu_pkg::PHASE_RED;
              end
              default: begin
                partial_rgb_next = '0;
                byte_phase_next  = bpu_pkg::PHASE_BLUE;
              end
            endcase
          end
        end
      end
    end
  end

  // Held word register
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_ready) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      a_word <= in_word;
    end
  end

  // Position state
  always_ff @(posedge clk) begin
    if (rst) begin
      sub            <= 3'd0;
      column_count   <= '0;
      row_count      <= '0;
      row_byte_count <= '0;
      partial_rgb    <= '0;
      byte_phase     <= bpu_pkg::PHASE_BLUE;
    end else begin
      sub            <= sub_next;
      column_count   <= column_count_next;
      row_count      <= row_count_next;
      row_byte_count <= row_byte_count_next;
      partial_rgb    <= partial_rgb_next;
      byte_phase     <= byte_phase_next;
    end
  end

  `BPU_ASSERT_IMP(a_err_is_last, clk, rst, issue_valid && issue.status, issue.last, "error result not marked last")
  `BPU_ASSERT_IMP(a_done_is_last, clk, rst, issue_valid && issue.done, issue.last, "image end inside a byte")
  `BPU_ASSERT_IMP(a_sub_multi, clk, rst, sub != 3'd0, a_valid && (a_word.cmd == bpu_pkg::CMD_PIXEL) && (bpp == bpu_pkg::BPP_1 || bpp == bpu_pkg::BPP_4), "sub-pixel position outside a packed byte")

endmodule

// ===== rtl/bpu_out_reg.sv =====
// Output register: holds one pixel and picks its color source.
`include "bmp_pixel_unpacker_macros.svh"
module bpu_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              issue_valid,
  input  bpu_pkg::pix_req_t issue,
  output logic              out_free,
  input  logic [23:0]       pal_rgb,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [47:0]       m_tdata,
  output logic              m_tlast,
  output logic [1:0]        m_tuser
);

  logic              b_valid;
  bpu_pkg::pix_req_t b_req;
  logic [7:0]        red, green, blue;

  assign out_free = !b_valid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (out_free) begin
      b_valid <= issue_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (issue_valid) begin
      b_req <= issue;
    end
  end

  // Color select: palette data arrives from the registered memory read
  always_comb begin
    case (b_req.src)
      bpu_pkg::SRC_DIRECT: begin
        red   = b_req.red;
        green = b_req.green;
        blue  = b_req.blue;
      end
      bpu_pkg::SRC_PALETTE: begin
        red   = pal_rgb[23:16];
        green = pal_rgb[15:8];
        blue  = pal_rgb[7:0];
      end
      default: begin
        red   = 8'd0;
        green = 8'd0;
        blue  = 8'd0;
      end
    endcase
  end

  assign m_tvalid = b_valid;
  assign m_tdata  = {blue, green, red, b_req.y, b_req.x};
  assign m_tlast  = b_req.last;
  assign m_tuser  = {b_req.status, b_req.done};

  `BPU_ASSERT_IMP(a_no_overrun, clk, rst, issue_valid, out_free, "pixel issued into a full output register")
  `BPU_ASSERT_IMP(a_err_black, clk, rst, b_valid && b_req.status, b_req.src == bpu_pkg::SRC_DIRECT && b_req.red == 8'd0 && b_req.green == 8'd0 && b_req.blue == 8'd0, "error result carries color")

endmodule

// ===== rtl/bmp_pixel_unpacker.sv =====
// Top level of the uncompressed bitmap pixel unpacker.
//
//  port group    dir  word contents (low bit first)
//  s_*           in   tdata: data_byte, palette_index, red, green, blue; tuser: cmd
//  m_*           out  tdata: pixel_x, pixel_y, red, green, blue; tuser: image_done, status;
//                     tlast: last_of_run
//  cfg_*         in   write-only registers: bits_per_pixel, image_width, image_height
//
// One word per cycle at 8 and 24 bpp, for palette writes, pad bytes and error results,
// while m_tready does not stall. A 4 bpp byte gives two pixels and a 1 bpp byte up to
// eight, one per cycle. Words pass the held word register, then the output register.
// Reset is synchronous; the palette holds no reset value and must be loaded before use.
// A stall on m_tready holds the output register and then the held input word.
module bmp_pixel_unpacker #(
  parameter int MAX_WIDTH     = 4096,
  parameter int MAX_HEIGHT    = 4096,
  parameter int PALETTE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  // input words
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // data_byte, palette_index, red, green, blue
  input  logic        s_tuser,   // cmd
  // pixel words
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // pixel_x, pixel_y, red, green, blue
  output logic        m_tlast,   // last_of_run
  output logic [1:0]  m_tuser,   // image_done, status
  // configuration
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data
);

  localparam int WW  = $clog2(MAX_WIDTH+1);
  localparam int HW  = $clog2(MAX_HEIGHT+1);
  localparam int CWW = (WW > bpu_pkg::CFG_DIM_W) ? WW : bpu_pkg::CFG_DIM_W;
  localparam int CHW = (HW > bpu_pkg::CFG_DIM_W) ? HW : bpu_pkg::CFG_DIM_W;
  localparam int BW  = $clog2(MAX_WIDTH*24+1);

  logic [5:0]  bits_per_pixel;
  logic [12:0] image_width;
  logic [12:0] image_height;

  logic [WW-1:0]     w;
  logic [HW-1:0]     h;
  logic [BW-1:0]     row_bits, row_bytes, padded;
  bpu_pkg::in_word_t in_word;

  logic              issue_valid;
  bpu_pkg::pix_req_t issue;
  bpu_pkg::pal_wr_t  pal_wr;
  logic              out_free;
  logic [23:0]       pal_rgb;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bits_per_pixel <= bpu_pkg::BPP_RESET;
      image_width    <= bpu_pkg::WIDTH_RESET;
      image_height   <= bpu_pkg::HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        bpu_pkg::REG_BPP:    bits_per_pixel <= cfg_data[5:0];
        bpu_pkg::REG_WIDTH:  image_width    <= cfg_data;
        bpu_pkg::REG_HEIGHT: image_height   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp the image size
  always_comb begin
    if (image_width == 13'd0) begin
      w = WW'(1);
    end else if (CWW'(image_width) > CWW'(MAX_WIDTH)) begin
      w = WW'(MAX_WIDTH);
    end else begin
      w = WW'(image_width);
    end
    if (image_height == 13'd0) begin
      h = HW'(1);
    end else if (CHW'(image_height) > CHW'(MAX_HEIGHT)) begin
      h = HW'(MAX_HEIGHT);
    end else begin
      h = HW'(image_height);
    end
  end

  // Stored row length, padded to four bytes
  always_comb begin
    case (bits_per_pixel)
      bpu_pkg::BPP_1: row_bits = BW'(w);
      bpu_pkg::BPP_4: row_bits = BW'(w) << 2;
      bpu_pkg::BPP_8: row_bits = BW'(w) << 3;
      default:        row_bits = (BW'(w) << 4) + (BW'(w) << 3);
    endcase
    row_bytes = (row_bits + BW'(7)) >> 3;
    padded    = (row_bytes + BW'(3)) & ~BW'(3);
  end

  // Unpack the input word
  always_comb begin
    in_word.cmd           = s_tuser;
    in_word.data_byte     = s_tdata[7:0];
    in_word.palette_index = s_tdata[15:8];
    in_word.red           = s_tdata[23:16];
    in_word.green         = s_tdata[31:24];
    in_word.blue          = s_tdata[39:32];
  end

  bpu_seq #(
    .MAX_WIDTH     (MAX_WIDTH),
    .MAX_HEIGHT    (MAX_HEIGHT),
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_word     (in_word),
    .bpp         (bits_per_pixel),
    .w           (w),
    .h           (h),
    .padded      (padded),
    .out_free    (out_free),
    .issue_valid (issue_valid),
    .issue       (issue),
    .pal_wr      (pal_wr)
  );

  bpu_palette #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk      (clk),
    .wr       (pal_wr),
    .rd_en    (issue_valid),
    .rd_index (issue.pal_index),
    .rd_data  (pal_rgb)
  );

  bpu_out_reg u_out (
    .clk         (clk),
    .rst         (rst),
    .issue_valid (issue_valid),
    .issue       (issue),
    .out_free    (out_free),
    .pal_rgb     (pal_rgb),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast),
    .m_tuser     (m_tuser)
  );

endmodule
